// ===== rtl/plpp_pkg.sv =====
// ----------------------------------------------------------------------------
// plpp_pkg
// Shared types, codes and the pixel packing function of the planar line to
// packed pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package plpp_pkg;

	localparam logic [1:0] FMT_COPY  = 2'd0;
	localparam logic [1:0] FMT_PACK4 = 2'd1;
	localparam logic [1:0] FMT_BGR   = 2'd2;

	localparam logic REG_PIXEL_FORMAT = 1'b0;
	localparam logic REG_LINE_BYTES   = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [1:0] {
		KIND_STORE,
		KIND_COPY,
		KIND_PACK,
		KIND_BGR
	} kind_t;

	typedef struct packed {
		logic [1:0]  pixel_format;
		logic [10:0] line_bytes;
		logic        clear;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] b;
		logic [7:0] p2;
		logic [7:0] p1;
		logic [7:0] p0;
		logic       line_end;
	} cmd_t;

	// pixel pair k: high pixel from bit 7-2k, low pixel from bit 6-2k, plane 3 is msb
	function automatic logic [7:0] pack_pair(input logic [3:0][7:0] p, input logic [1:0] k);
		logic [2:0] hb;
		logic [2:0] lb;
		logic [3:0] hi;
		logic [3:0] lo;
		hb = 3'd7 - {k, 1'b0};
		lb = hb - 3'd1;
		for (int pl = 0; pl < 4; pl++) begin
			hi[pl] = p[pl][hb];
			lo[pl] = p[pl][lb];
		end
		return {hi, lo};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/plpp_front.sv =====
// ----------------------------------------------------------------------------
// plpp_front
// Accepts plane words, tracks plane and byte position, stores planes that
// are held for later and reads them back when the closing plane arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module plpp_front #(
	parameter int MAX_LINE_BYTES = 1024
) (
	input  wire                clk,
	input  wire                arst_n,
	input  plpp_pkg::cfg_t     cfg,
	input  wire                plane_valid,
	output logic               plane_stall,
	input  wire  [7:0]         plane_byte,
	output logic               push,
	output plpp_pkg::cmd_t     push_cmd,
	input  wire                queue_full
);

	localparam int BW   = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
	localparam int LENW = ($clog2(MAX_LINE_BYTES + 1) > 11) ? $clog2(MAX_LINE_BYTES + 1) : 11;
	localparam logic [LENW-1:0] MAXL = LENW'(MAX_LINE_BYTES);

	logic [7:0] mem0 [MAX_LINE_BYTES];
	logic [7:0] mem1 [MAX_LINE_BYTES];
	logic [7:0] mem2 [MAX_LINE_BYTES];

	logic [1:0]      plane_q;
	logic [BW-1:0]   byte_q;
	logic [7:0]      rd0_q, rd1_q, rd2_q;

	logic            valid_s1;
	plpp_pkg::kind_t kind_s1;
	logic [7:0]      b_s1;
	logic            line_end_s1;

	logic [LENW-1:0] lb_ext, len, len_m1;
	logic [1:0]      last_plane;
	logic            byte_last, plane_last;
	plpp_pkg::kind_t kind;
	logic            accept, advance, wr_en, rd_en;

	always_comb begin
		lb_ext = LENW'(cfg.line_bytes);
		if (lb_ext == '0) begin
			len = LENW'(1);
		end else if (lb_ext > MAXL) begin
			len = MAXL;
		end else begin
			len = lb_ext;
		end
		len_m1 = len - LENW'(1);
	end

	always_comb begin
		unique case (cfg.pixel_format)
			plpp_pkg::FMT_PACK4: last_plane = 2'd3;
			plpp_pkg::FMT_BGR:   last_plane = 2'd2;
			default:             last_plane = 2'd0;
		endcase
	end

	assign byte_last  = (LENW'(byte_q) == len_m1);
	assign plane_last = (plane_q == last_plane);

	always_comb begin
		if (!plane_last) begin
			kind = plpp_pkg::KIND_STORE;
		end else begin
			unique case (cfg.pixel_format)
				plpp_pkg::FMT_PACK4: kind = plpp_pkg::KIND_PACK;
				plpp_pkg::FMT_BGR:   kind = plpp_pkg::KIND_BGR;
				default:             kind = plpp_pkg::KIND_COPY;
			endcase
		end
	end

	assign plane_stall = valid_s1 && (kind_s1 != plpp_pkg::KIND_STORE) && queue_full;
	assign accept      = plane_valid && !plane_stall;
	assign advance     = valid_s1 && ((kind_s1 == plpp_pkg::KIND_STORE) || !queue_full);
	assign push        = valid_s1 && (kind_s1 != plpp_pkg::KIND_STORE) && !queue_full;
	assign wr_en       = accept && (kind == plpp_pkg::KIND_STORE);
	assign rd_en       = accept && (kind != plpp_pkg::KIND_STORE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
			byte_q  <= '0;
		end else if (cfg.clear) begin
			plane_q <= '0;
			byte_q  <= '0;
		end else if (accept) begin
			if (byte_last) begin
				byte_q  <= '0;
				plane_q <= plane_last ? 2'd0 : plane_q + 2'd1;
			end else begin
				byte_q <= byte_q + BW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && plane_q == 2'd0) begin
			mem0[byte_q] <= plane_byte;
		end
		if (rd_en) begin
			rd0_q <= mem0[byte_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && plane_q == 2'd1) begin
			mem1[byte_q] <= plane_byte;
		end
		if (rd_en) begin
			rd1_q <= mem1[byte_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && plane_q == 2'd2) begin
			mem2[byte_q] <= plane_byte;
		end
		if (rd_en) begin
			rd2_q <= mem2[byte_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind;
			b_s1        <= plane_byte;
			line_end_s1 <= plane_last && byte_last;
		end
	end

	always_comb begin
		push_cmd.kind     = kind_s1;
		push_cmd.b        = b_s1;
		push_cmd.p2       = rd2_q;
		push_cmd.p1       = rd1_q;
		push_cmd.p0       = rd0_q;
		push_cmd.line_end = line_end_s1;
	end

endmodule

`default_nettype wire

// ===== rtl/plpp_queue.sv =====
// ----------------------------------------------------------------------------
// plpp_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module plpp_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  plpp_pkg::cmd_t     push_cmd,
	output logic               full,
	input  wire                pop,
	output logic               empty,
	output plpp_pkg::cmd_t     head
);

	plpp_pkg::cmd_t                 slots_q [plpp_pkg::QUEUE_DEPTH];
	logic [plpp_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [plpp_pkg::QPTR_W:0]      count_q;

	assign full  = (count_q == (plpp_pkg::QPTR_W + 1)'(plpp_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + plpp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + plpp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (plpp_pkg::QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (plpp_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/plpp_back.sv =====
// ----------------------------------------------------------------------------
// plpp_back
// Expands each queued command into one to four output words and holds the
// current word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plpp_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                empty,
	input  plpp_pkg::cmd_t     head,
	output logic               pop,
	output logic               pixel_valid,
	input  wire                pixel_stall,
	output logic [7:0]         pixel_byte,
	output logic               last_of_run,
	output logic               end_of_line
);

	logic [1:0] k_q;
	logic [1:0] k_last;
	logic [7:0] word;
	logic       last, load;

	always_comb begin
		word   = head.b;
		k_last = 2'd0;
		unique case (head.kind)
			plpp_pkg::KIND_PACK: begin
				k_last = 2'd3;
				word   = plpp_pkg::pack_pair({head.b, head.p2, head.p1, head.p0}, k_q);
			end
			plpp_pkg::KIND_BGR: begin
				k_last = 2'd2;
				case (k_q)
					2'd0:    word = head.b;
					2'd1:    word = head.p1;
					default: word = head.p0;
				endcase
			end
			default: begin
				k_last = 2'd0;
				word   = head.b;
			end
		endcase
	end

	assign last = (k_q == k_last);
	assign load = !empty && (!pixel_valid || !pixel_stall);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			pixel_valid <= 1'b0;
		end else begin
			pixel_valid <= load || (pixel_valid && pixel_stall);
			if (load) begin
				k_q <= last ? 2'd0 : k_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_byte  <= word;
			last_of_run <= last;
			end_of_line <= last && head.line_end;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/planar_line_to_packed_pixels.sv =====
// ----------------------------------------------------------------------------
// planar_line_to_packed_pixels
// Converts scan lines that arrive plane after plane into packed pixel words:
// plain copy, four planes to 4-bit pixel pairs, or three planes to BGR.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  plane     plane_valid / plane_stall  plane_byte[7:0]
//  pixel     pixel_valid / pixel_stall  pixel_byte[7:0], last_of_run, end_of_line
//  config    APB, psel/penable/pready   paddr[2:0], pwdata/prdata[31:0]
//
//  Stored planes take one cycle per word while the front stage is not held
//  by a full queue. A closing-plane word yields one, three or four output
//  words, one per cycle from the back end unless the output stalls. A word
//  moves through the front stage, the command queue and the output register.
//  A 4-deep command queue lets the front keep filling the plane store while
//  the output stalls. Reset sets format 0 and line length 1; any register
//  write restarts the line at plane 0.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_line_to_packed_pixels #(
	parameter int MAX_LINE_BYTES = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         plane_valid,
	output logic        plane_stall,
	input  wire  [7:0]  plane_byte,
	output logic        pixel_valid,
	input  wire         pixel_stall,
	output logic [7:0]  pixel_byte,
	output logic        last_of_run,
	output logic        end_of_line
);

	logic [1:0]     pixel_format_q;
	logic [10:0]    line_bytes_q;
	logic           cfg_wr;
	plpp_pkg::cfg_t cfg;

	logic           push, queue_full, pop, queue_empty;
	plpp_pkg::cmd_t push_cmd, head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= plpp_pkg::FMT_COPY;
			line_bytes_q   <= 11'd1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				plpp_pkg::REG_PIXEL_FORMAT: pixel_format_q <= pwdata[1:0];
				default:                    line_bytes_q   <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			plpp_pkg::REG_PIXEL_FORMAT: prdata = {30'd0, pixel_format_q};
			default:                    prdata = {21'd0, line_bytes_q};
		endcase
	end

	always_comb begin
		cfg.pixel_format = pixel_format_q;
		cfg.line_bytes   = line_bytes_q;
		cfg.clear        = cfg_wr;
	end

	plpp_front #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.plane_valid(plane_valid),
		.plane_stall(plane_stall),
		.plane_byte (plane_byte),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	plpp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (queue_full),
		.pop     (pop),
		.empty   (queue_empty),
		.head    (head)
	);

	plpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (queue_empty),
		.head       (head),
		.pop        (pop),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_byte (pixel_byte),
		.last_of_run(last_of_run),
		.end_of_line(end_of_line)
	);

endmodule

`default_nettype wire

// ===== rtl/plpp_checker.sv =====
// ----------------------------------------------------------------------------
// plpp_checker
// Port-level checks of the planar line to packed pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

module plpp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        psel,
	input wire        penable,
	input wire        pwrite,
	input wire [2:0]  paddr,
	input wire [31:0] pwdata,
	input wire [31:0] prdata,
	input wire        pready,
	input wire        pixel_valid,
	input wire        pixel_stall,
	input wire [7:0]  pixel_byte,
	input wire        last_of_run,
	input wire        end_of_line
);

	logic wr;
	assign wr = psel && penable && pwrite && pready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_byte))
		else $error("stalled pixel word changed");

	a_eol_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && end_of_line |-> last_of_run)
		else $error("end of line on a word that is not last of its run");

	a_fmt_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !paddr[2] |=> !(!paddr[2]) || prdata[1:0] == $past(pwdata[1:0]))
		else $error("pixel_format readback mismatch");

	a_len_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr && paddr[2] |=> !paddr[2] || prdata[10:0] == $past(pwdata[10:0]))
		else $error("line_bytes readback mismatch");

endmodule

bind planar_line_to_packed_pixels plpp_checker u_plpp_checker (.*);

`default_nettype wire
